### design/fbp_pkg.sv
`timescale 1ns / 1ps
package fbp_pkg;

    localparam int SLOTS     = 16;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int WAIT_W    = $clog2(SLOTS + 2);
    localparam int KB_W      = 18;
    localparam int FMT_W     = 32;
    localparam int AGE_W     = 32;
    localparam int MAXKB_W   = 22;
    localparam int TOT_W     = (KB_W + CNT_W > MAXKB_W) ? KB_W + CNT_W : MAXKB_W + 1;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 48;

    localparam logic [MAXKB_W-1:0] TOTAL_MAX  = 22'h3FFFFF;
    localparam logic [MAXKB_W-1:0] MAXKB_RST  = 22'd65536;

    localparam logic [1:0] OP_GET     = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;

    localparam logic [2:0] ST_REUSED   = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_NOROOM   = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FLUSHED  = 3'd5;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_BUSY    = 3'd1;
    localparam logic [2:0] CMD_EVICT   = 3'd2;
    localparam logic [2:0] CMD_ALLOC   = 3'd3;
    localparam logic [2:0] CMD_RELEASE = 3'd4;
    localparam logic [2:0] CMD_FLUSH   = 3'd5;

    typedef struct packed {
        logic [2:0]       code;
        logic [IDX_W-1:0] idx;
        logic [FMT_W-1:0] fmt;
        logic [KB_W-1:0]  kb;
        logic [AGE_W-1:0] age;
    } cmd_t;

    typedef struct packed {
        logic             hit_f;
        logic [IDX_W-1:0] hit_idx;
        logic             min_f;
        logic [IDX_W-1:0] min_idx;
        logic [AGE_W-1:0] min_age;
        logic             empty_f;
        logic [IDX_W-1:0] empty_idx;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] busy;
        logic [TOT_W-1:0] total;
    } rec_t;

endpackage

### design/fbp_cell.sv
`timescale 1ns / 1ps
module fbp_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [fbp_pkg::IDX_W-1:0] cell_idx,
    input  fbp_pkg::cmd_t        cmd,
    input  fbp_pkg::rec_t        rec_in,
    output fbp_pkg::rec_t        rec_out,
    output logic                 valid_o
);
    import fbp_pkg::*;

    logic             valid_reg, valid_next;
    logic             busy_reg, busy_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic [FMT_W-1:0] fmt_reg, fmt_next;
    logic [KB_W-1:0]  kb_reg, kb_next;
    rec_t             rec_reg, rec_next;
    logic             sel;
    logic             free;

    assign sel  = (cmd.idx == cell_idx);
    assign free = valid_reg && !busy_reg;

    always_comb begin
        valid_next = valid_reg;
        busy_next  = busy_reg;
        age_next   = age_reg;
        fmt_next   = fmt_reg;
        kb_next    = kb_reg;
        unique case (cmd.code)
            CMD_BUSY: begin
                if (sel) busy_next = 1'b1;
            end
            CMD_EVICT: begin
                if (sel) valid_next = 1'b0;
            end
            CMD_ALLOC: begin
                if (sel) begin
                    valid_next = 1'b1;
                    busy_next  = 1'b1;
                    fmt_next   = cmd.fmt;
                    kb_next    = cmd.kb;
                    age_next   = '0;
                end
            end
            CMD_RELEASE: begin
                if (sel) begin
                    busy_next = 1'b0;
                    age_next  = cmd.age;
                end
            end
            CMD_FLUSH: begin
                if (!busy_reg) valid_next = 1'b0;
            end
            default: ;
        endcase
    end

    // search record picks up this cell's contribution on its way down the row
    always_comb begin
        rec_next = rec_in;
        if (free && !rec_in.hit_f && fmt_reg == cmd.fmt) begin
            rec_next.hit_f   = 1'b1;
            rec_next.hit_idx = cell_idx;
        end
        if (free && (!rec_in.min_f || age_reg < rec_in.min_age)) begin
            rec_next.min_f   = 1'b1;
            rec_next.min_idx = cell_idx;
            rec_next.min_age = age_reg;
        end
        if (!valid_reg && !rec_in.empty_f) begin
            rec_next.empty_f   = 1'b1;
            rec_next.empty_idx = cell_idx;
        end
        if (valid_reg) begin
            rec_next.count = rec_in.count + 1'b1;
            rec_next.total = rec_in.total + TOT_W'(kb_reg);
            if (busy_reg) rec_next.busy = rec_in.busy + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
        end
        age_reg <= age_next;
        fmt_reg <= fmt_next;
        kb_reg  <= kb_next;
        rec_reg <= rec_next;
    end

    assign rec_out = rec_reg;
    assign valid_o = valid_reg;

endmodule

### design/frame_buffer_pool_lru.sv
`timescale 1ns / 1ps
// channel   ports            tdata fields (low bit first)
// s_        tvalid/tready    opcode, frame_width, frame_height, color_model,
//                            frame_kbytes, release_slot
// m_        tvalid/tready    status, slot, slot_count, busy_count, total_kbytes, evicted
// cfg_      wr_en/wr_data    max_kbytes
// each slot is a cell; a search record walks the row one cell a cycle. release and
// flush take two scans, a reuse two, a new allocation two plus one per eviction
// (up to SLOTS+2 scans).
// reset clears all slots, the moment counter and sets max_kbytes to 65536.
// s_tready is high whenever no item is in work; a held result does not block it.
module frame_buffer_pool_lru (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode, frame_width, frame_height, color_model, frame_kbytes, release_slot
    input  logic [fbp_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, slot, slot_count, busy_count, total_kbytes, evicted, zero pad
    output logic [fbp_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [fbp_pkg::MAXKB_W-1:0]   cfg_wr_data
);
    import fbp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]         state_reg;
    logic [WAIT_W-1:0]  cnt_reg;
    logic [1:0]         op_reg;
    logic [FMT_W-1:0]   fmt_reg;
    logic [KB_W-1:0]    kb_reg;
    logic [3:0]         rel_reg;
    logic [MAXKB_W-1:0] max_kbytes_reg;
    logic [AGE_W-1:0]   moment_reg;
    logic [CNT_W-1:0]   evicted_reg;
    logic [2:0]         status_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               extra_reg, final_reg, skip_reg;
    logic [2:0]         cmd_code_reg;
    logic [IDX_W-1:0]   cmd_idx_reg;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    cmd_t               cmd;
    rec_t               chain [SLOTS+1];
    logic [SLOTS-1:0]   valid_vec;
    rec_t               last;
    logic               rel_ok;
    logic [MAXKB_W-1:0] total_sat;
    logic               over;
    logic               decide;
    logic               evict_now;

    assign cmd.code = cmd_code_reg;
    assign cmd.idx  = cmd_idx_reg;
    assign cmd.fmt  = fmt_reg;
    assign cmd.kb   = kb_reg;
    assign cmd.age  = moment_reg;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            fbp_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cell_idx(IDX_W'(g)),
                .cmd     (cmd),
                .rec_in  (chain[g]),
                .rec_out (chain[g+1]),
                .valid_o (valid_vec[g])
            );
        end
    endgenerate

    assign last      = chain[SLOTS];
    assign rel_ok    = (32'(rel_reg) < SLOTS) && valid_vec[IDX_W'(rel_reg)];
    assign over      = last.total > TOT_W'(max_kbytes_reg);
    assign total_sat = (last.total > TOT_W'(TOTAL_MAX)) ? TOTAL_MAX : MAXKB_W'(last.total);
    assign decide    = (state_reg == S_SCAN) && (cnt_reg == WAIT_W'(SLOTS + 1)) && !final_reg;
    // a get that has to evict once more and scan again
    assign evict_now = !(!skip_reg && last.hit_f) && last.min_f && !extra_reg &&
                       (over || !last.empty_f);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            max_kbytes_reg <= MAXKB_RST;
            moment_reg     <= '0;
            cmd_code_reg   <= CMD_NONE;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) max_kbytes_reg <= cfg_wr_data;
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) m_tvalid_reg <= 1'b0;
            if (!decide) cmd_code_reg <= CMD_NONE;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= s_tdata[1:0];
                        fmt_reg     <= {s_tdata[14:2], s_tdata[27:15], s_tdata[33:28]};
                        kb_reg      <= s_tdata[51:34];
                        rel_reg     <= s_tdata[55:52];
                        evicted_reg <= '0;
                        extra_reg   <= 1'b0;
                        final_reg   <= 1'b0;
                        skip_reg    <= 1'b0;
                        status_reg  <= ST_NOTFOUND;
                        slot_reg    <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (cnt_reg != WAIT_W'(SLOTS + 1)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        cnt_reg <= '0;
                        if (final_reg) begin
                            state_reg <= S_OUT;
                        end else begin
                            final_reg <= !(op_reg == OP_GET && evict_now);
                            case (op_reg)
                                OP_GET: begin
                                    if (!skip_reg && last.hit_f) begin
                                        cmd_code_reg <= CMD_BUSY;
                                        cmd_idx_reg  <= last.hit_idx;
                                        status_reg   <= ST_REUSED;
                                        slot_reg     <= last.hit_idx;
                                    end else if (over && last.min_f && !extra_reg) begin
                                        skip_reg     <= 1'b1;
                                        cmd_code_reg <= CMD_EVICT;
                                        cmd_idx_reg  <= last.min_idx;
                                        evicted_reg  <= evicted_reg + 1'b1;
                                    end else if (last.empty_f) begin
                                        cmd_code_reg <= CMD_ALLOC;
                                        cmd_idx_reg  <= last.empty_idx;
                                        status_reg   <= ST_NEW;
                                        slot_reg     <= last.empty_idx;
                                    end else if (last.min_f && !extra_reg) begin
                                        // table full: make room with one more eviction
                                        skip_reg     <= 1'b1;
                                        extra_reg    <= 1'b1;
                                        cmd_code_reg <= CMD_EVICT;
                                        cmd_idx_reg  <= last.min_idx;
                                        evicted_reg  <= evicted_reg + 1'b1;
                                    end else begin
                                        status_reg <= ST_NOROOM;
                                        slot_reg   <= '0;
                                    end
                                end
                                OP_RELEASE: begin
                                    if (rel_ok) begin
                                        moment_reg   <= moment_reg + 1'b1;
                                        cmd_code_reg <= CMD_RELEASE;
                                        cmd_idx_reg  <= IDX_W'(rel_reg);
                                        status_reg   <= ST_RELEASED;
                                        slot_reg     <= IDX_W'(rel_reg);
                                    end
                                end
                                OP_FLUSH: begin
                                    cmd_code_reg <= CMD_FLUSH;
                                    evicted_reg  <= last.count - last.busy;
                                    status_reg   <= ST_FLUSHED;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, 5'(evicted_reg), total_sat, 5'(last.busy),
                                         5'(last.count), 4'(slot_reg), status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import fbp_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [12:0] fw;
        logic [12:0] fh;
        logic [5:0]  cm;
        logic [17:0] kb;
        logic [3:0]  rel;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [4:0]  count;
        logic [4:0]  busy;
        logic [21:0] total;
        logic [4:0]  evicted;
    } resp_t;

    localparam int WATCHDOG = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [MAXKB_W-1:0] cfg_wr_data = '0;

    frame_buffer_pool_lru dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // pool mirror
    logic        pv[SLOTS];
    logic        pb[SLOTS];
    logic [31:0] page[SLOTS];
    logic [31:0] pfmt[SLOTS];
    logic [17:0] pkb[SLOTS];
    logic [31:0] moment;
    logic [21:0] limit_kb;

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int    errors = 0;
    int    send_idle = 0;
    int    recv_stall = 0;
    bit    hold_off = 1'b0;
    bit    stim_done = 1'b0;
    int    quiet = 0;

    function automatic int pool_sum();
        int s = 0;
        for (int i = 0; i < SLOTS; i++) if (pv[i]) s += pkb[i];
        return s;
    endfunction

    function automatic bit drop_oldest_free();
        int best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (pv[i] && !pb[i] && (best < 0 || page[i] < page[best])) best = i;
        if (best < 0) return 1'b0;
        pv[best] = 1'b0;
        return 1'b1;
    endfunction

    function automatic int first_empty();
        for (int i = 0; i < SLOTS; i++) if (!pv[i]) return i;
        return -1;
    endfunction

    function automatic resp_t pool_apply(req_t r);
        resp_t o;
        logic [31:0] fmt;
        int hit, e, s;
        fmt = {r.fw, r.fh, r.cm};
        o = '0;
        o.status = ST_NOTFOUND;
        if (r.op == OP_GET) begin
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && pv[i] && !pb[i] && pfmt[i] == fmt) hit = i;
            if (hit >= 0) begin
                pb[hit] = 1'b1;
                o.status = ST_REUSED;
                o.slot = hit;
            end else begin
                while (pool_sum() > limit_kb && drop_oldest_free()) o.evicted++;
                e = first_empty();
                if (e < 0 && drop_oldest_free()) begin
                    o.evicted++;
                    e = first_empty();
                end
                if (e >= 0) begin
                    pv[e] = 1'b1; pb[e] = 1'b1; pfmt[e] = fmt; pkb[e] = r.kb; page[e] = 0;
                    o.slot = e;
                    o.status = ST_NEW;
                end else o.status = ST_NOROOM;
            end
        end else if (r.op == OP_RELEASE) begin
            if (pv[r.rel]) begin
                moment++;
                pb[r.rel] = 1'b0;
                page[r.rel] = moment;
                o.status = ST_RELEASED;
                o.slot = r.rel;
            end
        end else if (r.op == OP_FLUSH) begin
            for (int i = 0; i < SLOTS; i++)
                if (pv[i] && !pb[i]) begin
                    pv[i] = 1'b0;
                    o.evicted++;
                end
            o.status = ST_FLUSHED;
        end
        for (int i = 0; i < SLOTS; i++)
            if (pv[i]) begin
                o.count++;
                if (pb[i]) o.busy++;
            end
        s = pool_sum();
        o.total = (s > TOTAL_MAX) ? TOTAL_MAX : s;
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("error: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        req_t r;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_resps.push_back(pool_apply(pending_reqs.pop_front()));
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && ($urandom_range(99) >= send_idle)) begin
                    r = pending_reqs[0];
                    s_tdata <= {r.rel, r.kb, r.cm, r.fh, r.fw, r.op};
                    s_tvalid <= 1'b1;
                end else s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        resp_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[2:0], m_tdata[6:3], m_tdata[11:7], m_tdata[16:12],
                       m_tdata[38:17], m_tdata[43:39]};
                if (expected_resps.size() == 0) begin
                    $display("error: result with nothing expected");
                    errors++;
                end else begin
                    want = expected_resps.pop_front();
                    if (got.status != want.status) report_mismatch("status", got.status, want.status);
                    if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
                    if (got.count != want.count) report_mismatch("slot_count", got.count, want.count);
                    if (got.busy != want.busy) report_mismatch("busy_count", got.busy, want.busy);
                    if (got.total != want.total) report_mismatch("total_kbytes", got.total, want.total);
                    if (got.evicted != want.evicted)
                        report_mismatch("evicted", got.evicted, want.evicted);
                end
            end
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= WATCHDOG) begin
                $display("frame_buffer_pool_lru: mismatch");
                $finish;
            end
        end
    end

    function automatic req_t get_req(logic [12:0] fw, logic [12:0] fh, logic [5:0] cm,
                                     logic [17:0] kb);
        req_t r;
        r = '0;
        r.op = OP_GET; r.fw = fw; r.fh = fh; r.cm = cm; r.kb = kb;
        r.rel = $urandom_range(15);
        return r;
    endfunction

    function automatic req_t rel_req(logic [3:0] s);
        req_t r;
        r = '0;
        r.op = OP_RELEASE; r.rel = s;
        r.fw = $urandom; r.fh = $urandom; r.cm = $urandom; r.kb = $urandom;
        return r;
    endfunction

    function automatic req_t random_req();
        req_t r;
        int pick;
        pick = $urandom_range(99);
        // a few formats so that reuse really happens
        if (pick < 50) r = get_req($urandom_range(3), 13'd1080, $urandom_range(1), 
                                   $urandom_range(1) ? $urandom : $urandom_range(40000));
        else if (pick < 58) r = get_req($urandom, $urandom, $urandom, $urandom);
        else if (pick < 92) r = rel_req($urandom_range(15));
        else if (pick < 97) begin
            r = rel_req(0);
            r.op = OP_FLUSH;
        end else begin
            r = rel_req($urandom_range(15));
            r.op = 2'd3;
        end
        return r;
    endfunction

    task automatic drain_and_config(logic [21:0] value);
        while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_kb = value;
    endtask

    initial begin
        int holdn;
        for (int i = 0; i < SLOTS; i++) begin
            pv[i] = 0; pb[i] = 0; page[i] = 0; pfmt[i] = 0; pkb[i] = 0;
        end
        moment = 0;
        limit_kb = MAXKB_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every op, full table, no room, unused opcode
        pending_reqs.push_back(rel_req(4'd15));
        pending_reqs.push_back(get_req(13'h1FFF, 13'h1FFF, 6'h3F, 18'h3FFFF));
        pending_reqs.push_back(get_req(0, 0, 0, 0));
        pending_reqs.push_back(rel_req(4'd1));
        pending_reqs.push_back(rel_req(4'd0));
        pending_reqs.push_back(rel_req(4'd1));
        pending_reqs.push_back(get_req(0, 0, 0, 5));
        pending_reqs.push_back(get_req(1, 2, 3, 18'h3FFFF));
        for (int i = 0; i < 14; i++) pending_reqs.push_back(get_req(i + 7, 1, 1, 18'h3FFFF));
        pending_reqs.push_back(get_req(99, 9, 9, 1));
        begin
            req_t r;
            r = rel_req(4'd3);
            r.op = 2'd3;
            pending_reqs.push_back(r);
            r.op = OP_FLUSH;
            pending_reqs.push_back(r);
        end
        drain_and_config(22'h3FFFFF);
        pending_reqs.push_back(rel_req(4'd2));
        pending_reqs.push_back(rel_req(4'd5));
        pending_reqs.push_back(get_req(5, 5, 5, 1));

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0; recv_stall = 0; drain_and_config(22'd0); end
                1: begin send_idle = 66; recv_stall = 0; drain_and_config(22'd300000); end
                2: begin send_idle = 0; recv_stall = 66; drain_and_config(MAXKB_RST); end
                3: begin send_idle = 18; recv_stall = 18; drain_and_config(22'h3FFFFF); end
                default: begin send_idle = 0; recv_stall = 0; drain_and_config(22'd100000); end
            endcase
            for (int i = 0; i < 96; i++) pending_reqs.push_back(random_req());
            if (ph == 0) begin
                // hold the result side off so the input stalls
                hold_off = 1'b1;
                holdn = 0;
                while (holdn < 3000) begin
                    @(posedge aclk);
                    holdn++;
                end
                hold_off = 1'b0;
            end
        end
        while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0) $display("frame_buffer_pool_lru: match");
        else $display("frame_buffer_pool_lru: mismatch");
        $finish;
    end

endmodule

### sim.f
design/fbp_pkg.sv
design/fbp_cell.sv
design/frame_buffer_pool_lru.sv
tb/tb_top.sv
